FILE: rtl/eti_pkg.sv
package eti_pkg;

   // Fraction bits of progress and of the easing curves.
   localparam int FRAC_BITS = 16;

   // Fixed field widths.
   localparam int VAL_W  = 32;
   localparam int LEN_W  = 24;
   localparam int STEP_W = 16;
   localparam int ELAP_W = 32;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;

   // Derived arithmetic widths.
   localparam int ONE_W  = FRAC_BITS + 1;
   localparam int DIFF_W = VAL_W + 1;
   localparam int EASE_W = FRAC_BITS + 3;
   localparam int PROD_W = DIFF_W + EASE_W;
   localparam int RND_W  = PROD_W - FRAC_BITS;
   localparam int SUM_W  = RND_W + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS);

   localparam logic [ONE_W-1:0] FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ONE_W-1:0] FX_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

   // Overshoot constants of the out-back curve.
   localparam longint C1_INT = ((longint'(170158) << FRAC_BITS) + 50000) / 100000;
   localparam longint C3_INT = C1_INT + (longint'(1) << FRAC_BITS);
   localparam logic signed [DIFF_W-1:0] C1_OP = DIFF_W'(C1_INT);
   localparam logic signed [DIFF_W-1:0] C3_OP = DIFF_W'(C3_INT);

   typedef enum logic [IDX_W-1:0] {
      REG_START = 3'd0,
      REG_END   = 3'd1,
      REG_LEN   = 3'd2,
      REG_DELAY = 3'd3,
      REG_MODE  = 3'd4
   } reg_idx_type;

   typedef enum logic [MODE_W-1:0] {
      CURVE_LINEAR    = 2'd0,
      CURVE_OUT_CUBIC = 2'd1,
      CURVE_IN_OUT    = 2'd2,
      CURVE_OUT_BACK  = 2'd3
   } curve_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] start_value;
      logic signed [VAL_W-1:0] end_value;
      logic [LEN_W-1:0]        run_length;
      logic [LEN_W-1:0]        start_delay;
      curve_type               curve_mode;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] a;
      logic signed [EASE_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [RND_W-1:0] res;
   } mul_rsp_type;

endpackage

FILE: rtl/eti_ifs.sv
// Time step channel.
interface eti_req_if import eti_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] time_step;

   modport source (output valid, output time_step, input ready);
   modport sink   (input valid, input time_step, output ready);
endinterface

// Result channel.
interface eti_rsp_if import eti_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] current_value;
   logic                    completed;

   modport source (output valid, output current_value, output completed, input ready);
   modport sink   (input valid, input current_value, input completed, output ready);
endinterface

// Register write channel.
interface eti_csr_if import eti_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/eti_div.sv
module eti_div import eti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     dvs_ff, dvs_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LEN_W:0]       shifted;
   logic [LEN_W:0]       trial;
   logic                 fits;

   // One restoring step per cycle; the remainder stays below the divisor.
   assign shifted = {rem_ff, 1'b0};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.dividend;
         dvs_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(FRAC_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/eti_mul.sv
module eti_mul import eti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(FX_HALF);

   logic signed [DIFF_W-1:0] a_s;
   logic signed [EASE_W-1:0] b_s;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [PROD_W-1:0] bias_sum;
   logic signed [RND_W-1:0]  res_ff;
   logic                     v1_ff;
   logic                     done_ff;

   // First stage: signed product.
   assign a_s     = req.a;
   assign b_s     = req.b;
   assign prod_in = a_s * b_s;

   // Second stage: round to nearest, ties up, by adding half and flooring.
   assign bias_sum = prod_ff + HALF_P;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= req.start;
         done_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      res_ff  <= bias_sum[PROD_W-1:FRAC_BITS];
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

FILE: rtl/eti_ctrl.sv
module eti_ctrl import eti_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [STEP_W-1:0]       time_step,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] current_value,
   output logic                    completed,
   output div_req_type             div_req,
   input  div_rsp_type             div_rsp,
   output mul_req_type             mul_req,
   input  mul_rsp_type             mul_rsp
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CHECK = 8'b0000_0010,
      ST_RANGE = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_EASE  = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_WAIT  = 8'b0100_0000,
      ST_SUM   = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      OP_SQ   = 3'd0,
      OP_CUBE = 3'd1,
      OP_BK1  = 3'd2,
      OP_BK2  = 3'd3,
      OP_FIN  = 3'd4
   } mul_op_type;

   localparam logic signed [EASE_W-1:0] ONE_E = {{(EASE_W - ONE_W){1'b0}}, FX_ONE};
   localparam logic signed [SUM_W-1:0]  SAT_MAX =
      {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SAT_MIN =
      {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

   state_type                state_ff, state_in;
   mul_op_type               op_ff, op_in;
   logic [ELAP_W-1:0]        elapsed_ff, elapsed_in;
   logic                     finished_ff, finished_in;
   logic [ELAP_W-1:0]        active_ff, active_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [ONE_W-1:0]         t_ff, t_in;
   logic [ONE_W-1:0]         x_ff, x_in;
   logic signed [EASE_W-1:0] sq_ff, sq_in;
   logic signed [EASE_W-1:0] cube_ff, cube_in;
   logic signed [EASE_W-1:0] p1_ff, p1_in;
   logic signed [EASE_W-1:0] eased_ff, eased_in;
   logic signed [RND_W-1:0]  q_ff, q_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic [ELAP_W:0]          step_sum;
   logic [ELAP_W:0]          past_delay;
   logic [ONE_W-1:0]         u_val;
   logic                     t_low;
   logic signed [EASE_W-1:0] rnd_nar;
   logic signed [EASE_W-1:0] x_ext;
   logic signed [SUM_W-1:0]  total;
   logic signed [VAL_W-1:0]  sat_val;
   logic                     slot_free;

   // Shared datapath pieces of the sequencer.
   assign step_sum   = {1'b0, elapsed_ff} + {{(ELAP_W + 1 - STEP_W){1'b0}}, time_step};
   assign past_delay = {1'b0, elapsed_ff} - {{(ELAP_W + 1 - LEN_W){1'b0}}, cfg.start_delay};
   assign u_val      = FX_ONE - t_ff;
   assign t_low      = t_ff < FX_HALF;
   assign rnd_nar    = mul_rsp.res[EASE_W-1:0];
   assign x_ext      = {{(EASE_W - ONE_W){1'b0}}, x_ff};
   assign total      = {{(SUM_W - VAL_W){cfg.start_value[VAL_W-1]}}, cfg.start_value}
                       + {q_ff[RND_W-1], q_ff};
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Saturate the final sum to the signed 32-bit range.
   always_comb begin
      if (total > SAT_MAX) begin
         sat_val = {1'b0, {(VAL_W - 1){1'b1}}};
      end else if (total < SAT_MIN) begin
         sat_val = {1'b1, {(VAL_W - 1){1'b0}}};
      end else begin
         sat_val = total[VAL_W-1:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_req.start = (state_ff == ST_MUL);
      unique case (op_ff)
         OP_SQ: begin
            mul_req.a = {{(DIFF_W - ONE_W){1'b0}}, x_ff};
            mul_req.b = x_ext;
         end
         OP_CUBE: begin
            mul_req.a = {{(DIFF_W - ONE_W){1'b0}}, x_ff};
            mul_req.b = sq_ff;
         end
         OP_BK1: begin
            mul_req.a = C1_OP;
            mul_req.b = sq_ff;
         end
         OP_BK2: begin
            mul_req.a = C3_OP;
            mul_req.b = cube_ff;
         end
         OP_FIN: begin
            mul_req.a = diff_ff;
            mul_req.b = eased_ff;
         end
         default: begin
            mul_req.a = diff_ff;
            mul_req.b = eased_ff;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      elapsed_in       = elapsed_ff;
      finished_in      = finished_ff;
      active_in        = active_ff;
      diff_in          = diff_ff;
      t_in             = t_ff;
      x_in             = x_ff;
      sq_in            = sq_ff;
      cube_in          = cube_ff;
      p1_in            = p1_ff;
      eased_in         = eased_ff;
      q_in             = q_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_value_in     = rsp_value_ff;
      rsp_done_in      = rsp_done_ff;
      div_req.start    = 1'b0;
      div_req.dividend = active_ff[LEN_W-1:0];
      div_req.divisor  = cfg.run_length;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               elapsed_in = step_sum[ELAP_W] ? {ELAP_W{1'b1}} : step_sum[ELAP_W-1:0];
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (finished_ff || past_delay[ELAP_W]) begin
               state_in = ST_IDLE;
            end else begin
               active_in = past_delay[ELAP_W-1:0];
               diff_in   = {cfg.end_value[VAL_W-1], cfg.end_value}
                           - {cfg.start_value[VAL_W-1], cfg.start_value};
               state_in  = ST_RANGE;
            end
         end
         ST_RANGE: begin
            // Progress is full when the duration is zero or already covered.
            if (cfg.run_length == '0 ||
                active_ff >= {{(ELAP_W - LEN_W){1'b0}}, cfg.run_length}) begin
               t_in     = FX_ONE;
               state_in = ST_EASE;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               t_in     = {1'b0, div_rsp.quotient};
               state_in = ST_EASE;
            end
         end
         ST_EASE: begin
            x_in = (cfg.curve_mode == CURVE_IN_OUT && t_low) ? t_ff : u_val;
            if (cfg.curve_mode == CURVE_LINEAR) begin
               eased_in = {{(EASE_W - ONE_W){1'b0}}, t_ff};
               op_in    = OP_FIN;
            end else begin
               op_in = OP_SQ;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_rsp.done) begin
               state_in = ST_MUL;
               unique case (op_ff)
                  OP_SQ: begin
                     sq_in = rnd_nar;
                     op_in = (cfg.curve_mode == CURVE_OUT_BACK) ? OP_BK1 : OP_CUBE;
                  end
                  OP_BK1: begin
                     p1_in = rnd_nar;
                     op_in = OP_CUBE;
                  end
                  OP_CUBE: begin
                     cube_in = rnd_nar;
                     if (cfg.curve_mode == CURVE_OUT_BACK) begin
                        op_in = OP_BK2;
                     end else begin
                        if (cfg.curve_mode == CURVE_IN_OUT && t_low) begin
                           eased_in = rnd_nar <<< 2;
                        end else if (cfg.curve_mode == CURVE_IN_OUT) begin
                           eased_in = ONE_E - (rnd_nar <<< 2);
                        end else begin
                           eased_in = ONE_E - rnd_nar;
                        end
                        op_in = OP_FIN;
                     end
                  end
                  OP_BK2: begin
                     eased_in = ONE_E + p1_ff - rnd_nar;
                     op_in    = OP_FIN;
                  end
                  OP_FIN: begin
                     q_in     = mul_rsp.res;
                     state_in = ST_SUM;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUM: begin
            // Hand the result to the output register once it is free.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sat_val;
               rsp_done_in  = (t_ff == FX_ONE);
               finished_in  = finished_ff || (t_ff == FX_ONE);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SQ;
         elapsed_ff   <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         elapsed_ff   <= elapsed_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      active_ff    <= active_in;
      diff_ff      <= diff_in;
      t_ff         <= t_in;
      x_ff         <= x_in;
      sq_ff        <= sq_in;
      cube_ff      <= cube_in;
      p1_ff        <= p1_in;
      eased_ff     <= eased_in;
      q_ff         <= q_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign current_value = rsp_value_ff;
   assign completed     = rsp_done_ff;

endmodule

FILE: rtl/eased_tween_interpolator_top.sv
// A result is registered after its transaction is accepted and passes the check and range
// states, the serial divider when progress is not yet full (one quotient bit per cycle),
// the ease state, 1 (linear), 3 (cubic curves) or 5 (out back) multiplies and the sum state.
// Throughput: one item at a time; the next is taken the cycle after its result is queued,
// or after the check state when the item gives no result. A result still held on the
// output stalls the next one in its last step until it is taken.
// Reset (synchronous, active high) clears the config and control registers, elapsed time and the finished flag.
module eased_tween_interpolator_top import eti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   eti_req_if.sink     req_ch,
   eti_rsp_if.source   rsp_ch,
   eti_csr_if.sink     csr_ch
);

   cfg_type     cfg_ff;
   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // Configuration registers; writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value <= '0;
         cfg_ff.end_value   <= '0;
         cfg_ff.run_length  <= '0;
         cfg_ff.start_delay <= '0;
         cfg_ff.curve_mode  <= CURVE_LINEAR;
      end else if (csr_ch.valid) begin
         unique case (reg_idx_type'(csr_ch.index))
            REG_START: cfg_ff.start_value <= csr_ch.wdata[VAL_W-1:0];
            REG_END:   cfg_ff.end_value   <= csr_ch.wdata[VAL_W-1:0];
            REG_LEN:   cfg_ff.run_length  <= csr_ch.wdata[LEN_W-1:0];
            REG_DELAY: cfg_ff.start_delay <= csr_ch.wdata[LEN_W-1:0];
            REG_MODE:  cfg_ff.curve_mode  <= curve_type'(csr_ch.wdata[MODE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Sequencer with the shared units.
   eti_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .time_step     (req_ch.time_step),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .current_value (rsp_ch.current_value),
      .completed     (rsp_ch.completed),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .mul_req       (mul_req),
      .mul_rsp       (mul_rsp)
   );

   eti_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   eti_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

endmodule
